>>> rtl/apbd_pkg.sv
`default_nettype none
package apbd_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic signed [11:0] PRED_RESET = -12'sd2;
	localparam logic signed [13:0] PRED_MAX = 14'sd2047;
	localparam logic signed [13:0] PRED_MIN = -14'sd2048;
	localparam logic signed [7:0] STEP_IDX_MAX = 8'sd48;
	localparam logic [5:0] VOLUME_RESET = 6'd32;
	localparam logic [6:0] VOLUME_FULL = 7'd32;
	localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
	localparam logic signed [18:0] SAMPLE_MIN = -19'sd32768;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_DATA,
		KIND_DONE
	} apbd_kind_t;

	typedef struct packed {
		logic restart;
		apbd_kind_t kind;
		logic [7:0] data;
	} apbd_entry_t;

	function automatic logic [10:0] step_size(input logic [5:0] idx);
		logic [10:0] st;
		case (idx)
			6'd0: st = 11'd16;
			6'd1: st = 11'd17;
			6'd2: st = 11'd19;
			6'd3: st = 11'd21;
			6'd4: st = 11'd23;
			6'd5: st = 11'd25;
			6'd6: st = 11'd28;
			6'd7: st = 11'd31;
			6'd8: st = 11'd34;
			6'd9: st = 11'd37;
			6'd10: st = 11'd41;
			6'd11: st = 11'd45;
			6'd12: st = 11'd50;
			6'd13: st = 11'd55;
			6'd14: st = 11'd60;
			6'd15: st = 11'd66;
			6'd16: st = 11'd73;
			6'd17: st = 11'd80;
			6'd18: st = 11'd88;
			6'd19: st = 11'd97;
			6'd20: st = 11'd107;
			6'd21: st = 11'd118;
			6'd22: st = 11'd130;
			6'd23: st = 11'd143;
			6'd24: st = 11'd157;
			6'd25: st = 11'd173;
			6'd26: st = 11'd190;
			6'd27: st = 11'd209;
			6'd28: st = 11'd230;
			6'd29: st = 11'd253;
			6'd30: st = 11'd279;
			6'd31: st = 11'd307;
			6'd32: st = 11'd337;
			6'd33: st = 11'd371;
			6'd34: st = 11'd408;
			6'd35: st = 11'd449;
			6'd36: st = 11'd494;
			6'd37: st = 11'd544;
			6'd38: st = 11'd598;
			6'd39: st = 11'd658;
			6'd40: st = 11'd724;
			6'd41: st = 11'd796;
			6'd42: st = 11'd876;
			6'd43: st = 11'd963;
			6'd44: st = 11'd1060;
			6'd45: st = 11'd1166;
			6'd46: st = 11'd1282;
			6'd47: st = 11'd1411;
			6'd48: st = 11'd1552;
			default: st = 11'd1552;
		endcase
		return st;
	endfunction

	function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
		logic signed [4:0] adj;
		case (code)
			3'd4: adj = 5'sd2;
			3'd5: adj = 5'sd4;
			3'd6: adj = 5'sd6;
			3'd7: adj = 5'sd8;
			default: adj = -5'sd1;
		endcase
		return adj;
	endfunction

endpackage
`default_nettype wire

>>> rtl/apbd_front.sv
`default_nettype none
module apbd_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] data_byte,
	input wire logic phrase_start,
	input wire logic q_full,
	output logic push,
	output apbd_pkg::apbd_entry_t push_entry
);
	import apbd_pkg::*;

	logic active_q;
	logic hdr_q;
	logic [6:0] left_q;

	logic accept;
	logic eff_active;
	logic eff_hdr;
	logic active_d;
	logic hdr_d;
	logic [6:0] left_d;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign eff_active = phrase_start || active_q;
	assign eff_hdr = phrase_start || hdr_q;

	always_comb begin
		active_d = active_q;
		hdr_d = hdr_q;
		left_d = left_q;
		push = 1'b0;
		push_entry.restart = phrase_start;
		push_entry.kind = KIND_NONE;
		push_entry.data = data_byte;
		if (accept && eff_active) begin
			if (eff_hdr) begin
				if (data_byte[6:0] == 7'd0) begin
					// end of phrase
					push = 1'b1;
					push_entry.kind = KIND_DONE;
					active_d = 1'b0;
					hdr_d = 1'b1;
					left_d = 7'd0;
				end else begin
					push = phrase_start;
					active_d = 1'b1;
					hdr_d = 1'b0;
					left_d = data_byte[6:0];
				end
			end else begin
				push = 1'b1;
				push_entry.kind = KIND_DATA;
				left_d = left_q - 7'd1;
				hdr_d = (left_q == 7'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			hdr_q <= 1'b1;
			left_q <= 7'd0;
		end else begin
			active_q <= active_d;
			hdr_q <= hdr_d;
			left_q <= left_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/apbd_queue.sv
`default_nettype none
module apbd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire apbd_pkg::apbd_entry_t push_entry,
	output logic full,
	output logic head_valid,
	output apbd_pkg::apbd_entry_t head_entry,
	input wire logic pop
);
	import apbd_pkg::*;

	apbd_entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	logic do_pop;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + (QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/apbd_back.sv
`default_nettype none
module apbd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [5:0] cfg_volume,
	input wire logic q_valid,
	input wire apbd_pkg::apbd_entry_t q_head,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [15:0] sample,
	output logic signed [11:0] predictor,
	output logic last_of_byte,
	output logic phrase_done
);
	import apbd_pkg::*;

	logic [5:0] volume_q;
	logic signed [11:0] pred_q;
	logic [5:0] idx_q;
	logic nib_q;

	logic valid_s1;
	logic signed [11:0] pred_s1;
	logic last_s1;
	logic done_s1;

	logic valid_s2;
	logic signed [15:0] sample_s2;
	logic signed [11:0] pred_s2;
	logic last_s2;
	logic done_s2;

	logic s2_free;
	logic s1_free;
	logic step;
	logic emit;
	logic signed [11:0] base_pred;
	logic [5:0] base_idx;
	logic [3:0] code;
	logic [10:0] st;
	logic [11:0] diff;
	logic signed [13:0] sum;
	logic signed [11:0] new_pred;
	logic signed [7:0] idx_sum;
	logic [5:0] new_idx;

	logic [6:0] vol_eff;
	logic signed [18:0] prod;
	logic signed [18:0] prod_rnd;
	logic signed [18:0] half;
	logic signed [15:0] scaled;

	assign s2_free = !valid_s2 || out_ready;
	assign s1_free = !valid_s1 || s2_free;

	always_comb begin
		step = 1'b0;
		emit = 1'b0;
		q_pop = 1'b0;
		case (q_head.kind)
			KIND_DATA: begin
				step = q_valid && s1_free;
				emit = step;
				q_pop = step && nib_q;
			end
			KIND_DONE: begin
				step = q_valid && s1_free;
				emit = step;
				q_pop = step;
			end
			default: begin
				step = q_valid;
				q_pop = step;
			end
		endcase
	end

	// nibble decode
	always_comb begin
		base_pred = q_head.restart ? PRED_RESET : pred_q;
		base_idx = q_head.restart ? 6'd0 : idx_q;
		code = nib_q ? q_head.data[3:0] : q_head.data[7:4];
		st = step_size(base_idx);
		diff = 12'(st >> 3)
			+ (code[2] ? 12'(st) : 12'd0)
			+ (code[1] ? 12'(st >> 1) : 12'd0)
			+ (code[0] ? 12'(st >> 2) : 12'd0);
		if (code[3]) begin
			sum = 14'(base_pred) - $signed({2'b00, diff});
		end else begin
			sum = 14'(base_pred) + $signed({2'b00, diff});
		end
		if (sum > PRED_MAX) begin
			new_pred = PRED_MAX[11:0];
		end else if (sum < PRED_MIN) begin
			new_pred = PRED_MIN[11:0];
		end else begin
			new_pred = sum[11:0];
		end
		idx_sum = $signed({2'b00, base_idx}) + 8'(index_adjust(code[2:0]));
		if (idx_sum > STEP_IDX_MAX) begin
			new_idx = STEP_IDX_MAX[5:0];
		end else if (idx_sum < 8'sd0) begin
			new_idx = 6'd0;
		end else begin
			new_idx = idx_sum[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= VOLUME_RESET;
			pred_q <= PRED_RESET;
			idx_q <= 6'd0;
			nib_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				volume_q <= cfg_volume;
			end
			if (step) begin
				if (q_head.kind == KIND_DATA) begin
					pred_q <= new_pred;
					idx_q <= new_idx;
					nib_q <= !nib_q;
				end else begin
					pred_q <= base_pred;
					idx_q <= base_idx;
					nib_q <= 1'b0;
				end
			end
		end
	end

	// decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			valid_s1 <= 1'b1;
		end else if (s2_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (q_head.kind == KIND_DATA) begin
				pred_s1 <= new_pred;
				last_s1 <= nib_q;
				done_s1 <= 1'b0;
			end else begin
				pred_s1 <= base_pred;
				last_s1 <= 1'b1;
				done_s1 <= 1'b1;
			end
		end
	end

	// volume scaling
	always_comb begin
		vol_eff = (volume_q == 6'd0) ? VOLUME_FULL : {1'b0, volume_q};
		prod = 19'(pred_s1) * $signed({12'd0, vol_eff});
		prod_rnd = prod + 19'(prod[18]);
		half = prod_rnd >>> 1;
		if (done_s1) begin
			scaled = 16'sd0;
		end else if (half > SAMPLE_MAX) begin
			scaled = SAMPLE_MAX[15:0];
		end else if (half < SAMPLE_MIN) begin
			scaled = SAMPLE_MIN[15:0];
		end else begin
			scaled = half[15:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			sample_s2 <= scaled;
			pred_s2 <= pred_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;
		end
	end

	assign out_valid = valid_s2;
	assign sample = sample_s2;
	assign predictor = pred_s2;
	assign last_of_byte = last_s2;
	assign phrase_done = done_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		nib_q |-> (q_valid && q_head.kind == KIND_DATA))
		else $error("second nibble pending without a data entry at the head");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> (sample_s2 == 16'sd0 && last_s2))
		else $error("end of phrase result not closing with a zero sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= STEP_IDX_MAX[5:0])
		else $error("step index beyond table");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step && q_head.kind == KIND_DATA && !nib_q) |-> (!q_pop ##1 nib_q))
		else $error("data entry left the queue after one nibble");

endmodule
`default_nettype wire

>>> rtl/adpcm_phrase_block_decoder.sv
// path: a data byte passes through the queue, the decode register and the output register;
// its second result follows its first, and an end of phrase result takes the same path
// throughput: the back end decodes one nibble per cycle while the output is not stalled;
// phrase start headers and end headers each pass through the back end, other headers and ignored bytes
// do not; a 4-entry queue absorbs bursts
// reset: arst_n clears framing (header expected, inactive), predictor to -2, index 0, volume 32
`default_nettype none
module adpcm_phrase_block_decoder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [5:0] cfg_data,       // volume
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata,   // data_byte
	input wire logic [0:0] s_axis_tuser,   // phrase_start
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [31:0] m_axis_tdata,      // sample [15:0], predictor [27:16], zero pad
	output logic m_axis_tlast,             // last_of_byte
	output logic [0:0] m_axis_tuser        // phrase_done
);
	import apbd_pkg::*;

	logic q_full;
	logic push;
	apbd_entry_t push_entry;
	logic head_valid;
	apbd_entry_t head_entry;
	logic pop;
	logic signed [15:0] sample;
	logic signed [11:0] predictor;

	assign cfg_ready = 1'b1;

	apbd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.data_byte(s_axis_tdata),
		.phrase_start(s_axis_tuser[0]),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	apbd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(q_full),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop(pop)
	);

	apbd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_volume(cfg_data),
		.q_valid(head_valid),
		.q_head(head_entry),
		.q_pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sample(sample),
		.predictor(predictor),
		.last_of_byte(m_axis_tlast),
		.phrase_done(m_axis_tuser[0])
	);

	assign m_axis_tdata = {4'd0, predictor, sample};

endmodule
`default_nettype wire

>>> tb/sv/adpcm_phrase_block_decoder_test.sv
`default_nettype none
module adpcm_phrase_block_decoder_test;
	import apbd_pkg::*;

	typedef struct {
		logic signed [15:0] sample;
		logic signed [11:0] pred;
		logic last;
		logic done;
	} nibble_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic [0:0] m_axis_tuser;

	adpcm_phrase_block_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	int step_table [0:48] = '{
		16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
		73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
		337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963, 1060, 1166, 1282, 1411,
		1552
	};

	// decoder state mirror
	int vol_reg;
	bit hdr_wait;
	int blk_left;
	int pred_acc;
	int step_pos;
	bit playing;

	nibble_result_t pending_q[$];
	int errors = 0;
	int bytes_decoded = 0;
	int results_seen = 0;
	int phrases_ended = 0;
	int sat_samples = 0;
	bit no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int step_adjust(input logic [2:0] code);
		if (code < 3'd4)
			return -1;
		return (int'(code) - 3) * 2;
	endfunction

	function automatic int scaled(input int p);
		int v;
		int s;
		v = (vol_reg == 0) ? 32 : vol_reg;
		s = p * v / 2;
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		return s;
	endfunction

	function automatic void push_nibble(input logic [3:0] code, input logic last);
		int st;
		int diff;
		nibble_result_t r;
		st = step_table[step_pos];
		diff = st / 8;
		if (code[2]) diff += st;
		if (code[1]) diff += st / 2;
		if (code[0]) diff += st / 4;
		if (code[3]) diff = -diff;
		pred_acc += diff;
		if (pred_acc > 2047) pred_acc = 2047;
		else if (pred_acc < -2048) pred_acc = -2048;
		step_pos += step_adjust(code[2:0]);
		if (step_pos > 48) step_pos = 48;
		else if (step_pos < 0) step_pos = 0;
		r.sample = 16'(scaled(pred_acc));
		r.pred = 12'(pred_acc);
		r.last = last;
		r.done = 1'b0;
		pending_q.push_back(r);
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic st);
		nibble_result_t r;
		if (st) begin
			pred_acc = int'(PRED_RESET);
			step_pos = 0;
			hdr_wait = 1'b1;
			blk_left = 0;
			playing = 1'b1;
		end
		if (!playing)
			return;
		if (hdr_wait) begin
			if (b[6:0] == 7'd0) begin
				playing = 1'b0;
				r.sample = '0;
				r.pred = 12'(pred_acc);
				r.last = 1'b1;
				r.done = 1'b1;
				pending_q.push_back(r);
			end else begin
				blk_left = int'(b[6:0]);
				hdr_wait = 1'b0;
			end
			return;
		end
		push_nibble(b[7:4], 1'b0);
		push_nibble(b[3:0], 1'b1);
		blk_left = (blk_left - 1) & 8'h7f;
		if (blk_left == 0)
			hdr_wait = 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= st;
		do @(posedge clk); while (!s_axis_tready);
		if (st || playing)
			bytes_decoded++;
		decode_byte(b, st);
	endtask

	// stop sending, wait until all results are back and the block has settled
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_volume(input logic [5:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vol_reg = int'(v);
	endtask

	function automatic logic [3:0] pick_code(input int mode);
		if (mode == 0 || $urandom_range(0, 99) < 20)
			return 4'($urandom);
		if (mode == 1)
			return 4'($urandom_range(4, 7));
		return 4'($urandom_range(12, 15));
	endfunction

	task automatic play_phrase();
		int mode;
		int nblk;
		int cnt;
		int k;
		int j;
		int r;
		r = $urandom_range(0, 99);
		mode = (r < 50) ? 0 : (r < 75) ? 1 : 2;
		nblk = $urandom_range(1, 4);
		for (k = 0; k < nblk; k++) begin
			cnt = ($urandom_range(0, 99) < 6) ? $urandom_range(7, 30) : $urandom_range(1, 6);
			send_byte({1'($urandom), 7'(cnt)}, k == 0);
			for (j = 0; j < cnt; j++) begin
				// broken phrase: the next start cuts it off
				if ($urandom_range(0, 199) == 0)
					return;
				send_byte({pick_code(mode), pick_code(mode)}, 1'b0);
			end
		end
		r = $urandom_range(0, 99);
		if (r < 90)
			send_byte({1'($urandom), 7'd0}, 1'b0);
		if (r >= 80)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic test_inactive_bytes();
		send_byte(8'h05, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_framing();
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h82, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hf0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h7f, 1'b1);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h0f, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_volume_sweep();
		logic [5:0] vols [0:7];
		int target;
		int p;
		vols = '{6'd32, 6'd0, 6'd63, 6'd16, 6'd8, 6'd1, 6'd33, 6'd48};
		for (p = 0; p < 8; p++) begin
			write_volume(vols[p]);
			no_idle = (p == 3);
			target = bytes_decoded + 56;
			while (bytes_decoded < target)
				play_phrase();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		vol_reg = int'(VOLUME_RESET);
		hdr_wait = 1'b1;
		blk_left = 0;
		pred_acc = int'(PRED_RESET);
		step_pos = 0;
		playing = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_inactive_bytes();
		test_framing();
		test_volume_sweep();
		settle();
		$display("%0d bytes decoded, %0d results checked, %0d phrase ends, %0d clipped samples",
			bytes_decoded, results_seen, phrases_ended, sat_samples);
		$display("volumes 32, 0, 63, 16, 8, 1, 33, 48 with random idling on both sides");
		if (errors == 0 && pending_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int n;
		int gap;
		@(posedge clk);
		forever begin
			n = $urandom_range(1, 8);
			m_axis_tready <= 1'b1;
			repeat (n) @(posedge clk);
			gap = idle_len();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		nibble_result_t e;
		logic [31:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result tdata=%h tlast=%b tuser=%b", $time,
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				e = pending_q.pop_front();
				want = {4'b0, e.pred, e.sample};
				if (e.done) phrases_ended++;
				if (e.sample == 16'sh7fff || e.sample == -16'sh8000) sat_samples++;
				if (m_axis_tdata !== want || m_axis_tlast !== e.last ||
						m_axis_tuser[0] !== e.done) begin
					errors++;
					$display("%0t mismatch: expected sample=%0d pred=%0d last=%b done=%b",
						$time, e.sample, e.pred, e.last, e.done);
					$display("%0t          actual sample=%0d pred=%0d last=%b done=%b pad=%h",
						$time, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[27:16]),
						m_axis_tlast, m_axis_tuser[0], m_axis_tdata[31:28]);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> files.f
rtl/apbd_pkg.sv
rtl/apbd_front.sv
rtl/apbd_queue.sv
rtl/apbd_back.sv
rtl/adpcm_phrase_block_decoder.sv
tb/sv/adpcm_phrase_block_decoder_test.sv
